>>> hw/rtl/vsdf_pkg.sv
// ----------------------------------------------------------------------------
// vsdf_pkg
// Shared types, codes and fixed-point widths of the voxel distance fill engine.
// ----------------------------------------------------------------------------
package vsdf_pkg;

    // Default grid capacity per axis.
    localparam int C_MAX_CELLS_X = 32;
    localparam int C_MAX_CELLS_Y = 32;
    localparam int C_MAX_CELLS_Z = 32;

    // Fixed-point widths (Q.9 internal values, capacity up to 256 per axis).
    localparam int C_IDX_W  = 8;   // cell index on one axis
    localparam int C_PT2_W  = 25;  // doubled input point, signed Q.9
    localparam int C_CTR_W  = 25;  // cell center (2i+1)*pitch, unsigned Q.9
    localparam int C_DIFF_W = 27;  // signed axis difference
    localparam int C_MAG_W  = 26;  // axis difference magnitude
    localparam int C_SQ_W   = 54;  // sum of three squares
    localparam int C_ROOT_W = C_SQ_W / 2;
    localparam int C_D9_W   = 29;  // signed distance before rounding

    localparam logic signed [23:0] C_DIST_INF = 24'sh7FFFFF;
    localparam logic signed [23:0] C_DIST_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        OP_FILL_SPHERE = 3'd0,
        OP_FILL_BOX    = 3'd1,
        OP_CLEAR       = 3'd2,
        OP_READ        = 3'd3,
        OP_WRITE       = 3'd4,
        OP_COUNT       = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_RADIUS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_CELLS_X    = 2'd0,
        REG_CELLS_Y    = 2'd1,
        REG_CELLS_Z    = 2'd2,
        REG_CELL_PITCH = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef logic signed [C_PT2_W-1:0] t_pt2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [23:0] point_a_x;
        logic signed [23:0] point_a_y;
        logic signed [23:0] point_a_z;
        logic signed [23:0] point_b_x;
        logic signed [23:0] point_b_y;
        logic signed [23:0] point_b_z;
        logic signed [23:0] size_or_distance;
        logic [7:0]         paint_red;
        logic [7:0]         paint_green;
        logic [7:0]         paint_blue;
        logic               write_active;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               cell_active;
        logic [7:0]         cell_red;
        logic [7:0]         cell_green;
        logic [7:0]         cell_blue;
        logic signed [23:0] cell_distance;
        logic [15:0]        active_total;
    } t_out;

    // One grid cell as held in the store.
    typedef struct packed {
        logic signed [23:0] distance;
        logic               active;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_cell;

endpackage

>>> hw/rtl/vsdf_store.sv
// ----------------------------------------------------------------------------
// vsdf_store
// Cell store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vsdf_store import vsdf_pkg::*; #(
    parameter int DEPTH = C_MAX_CELLS_X * C_MAX_CELLS_Y * C_MAX_CELLS_Z,
    parameter int AW    = 15
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vsdf_dist.sv
// ----------------------------------------------------------------------------
// vsdf_dist
// Four-stage front end: cell center, per-axis offset to the shape, squares
// and their sum, with the box interior term carried alongside.
// ----------------------------------------------------------------------------
module vsdf_dist import vsdf_pkg::*; #(
    parameter int AW = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_box,
    input  logic [C_IDX_W-1:0]         i_idx [3],
    input  logic [15:0]                i_pitch,
    input  t_pt2                       i_lo [3],
    input  t_pt2                       i_hi [3],
    input  logic [AW-1:0]              i_addr,
    output logic                       o_valid,
    output logic [C_SQ_W-1:0]          o_sum,
    output logic signed [C_DIFF_W-1:0] o_inside,
    output logic [AW-1:0]              o_addr
);

    logic                       r1_v, r2_v, r3_v, r4_v;
    logic [AW-1:0]              r1_addr, r2_addr, r3_addr, r4_addr;
    logic [C_CTR_W-1:0]         r1_c [3];
    logic [C_MAG_W-1:0]         r2_mag [3];
    logic signed [C_DIFF_W-1:0] r2_inside, r3_inside, r4_inside;
    logic [2*C_MAG_W-1:0]       r3_sq [3];
    logic [C_SQ_W-1:0]          r4_sum;

    logic [C_MAG_W-1:0]         mag [3];
    logic signed [C_DIFF_W-1:0] f_max;

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Stage 1: cell center in Q.9 on each axis.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_c[k] <= C_CTR_W'({i_idx[k], 1'b1}) * C_CTR_W'(i_pitch);
        end
        r1_addr <= i_addr;
    end

    // Stage 2: offset magnitude per axis and the box interior term.
    always_comb begin
        logic signed [C_DIFF_W-1:0] ce, lo, hi, dd, f;
        f_max = '0;
        for (int k = 0; k < 3; k++) begin
            ce = signed'(C_DIFF_W'(r1_c[k]));
            lo = C_DIFF_W'(i_lo[k]);
            hi = C_DIFF_W'(i_hi[k]);
            dd = ce - lo;
            f  = ((lo - ce) > (ce - hi)) ? (lo - ce) : (ce - hi);
            if (i_box) begin
                mag[k] = (f > 0) ? f[C_MAG_W-1:0] : '0;
                if (k == 0 || f > f_max) begin
                    f_max = f;
                end
            end else begin
                mag[k] = (dd < 0) ? C_MAG_W'(-dd) : C_MAG_W'(dd);
            end
        end
        if (f_max > 0) begin
            f_max = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mag    <= mag;
        r2_inside <= f_max;
        r2_addr   <= r1_addr;
    end

    // Stage 3: squares.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_sq[k] <= r2_mag[k] * r2_mag[k];
        end
        r3_inside <= r2_inside;
        r3_addr   <= r2_addr;
    end

    // Stage 4: sum of squares.
    always_ff @(posedge i_clk) begin
        r4_sum    <= C_SQ_W'(r3_sq[0]) + C_SQ_W'(r3_sq[1]) + C_SQ_W'(r3_sq[2]);
        r4_inside <= r3_inside;
        r4_addr   <= r3_addr;
    end

    assign o_valid  = r4_v;
    assign o_sum    = r4_sum;
    assign o_inside = r4_inside;
    assign o_addr   = r4_addr;

endmodule

>>> hw/rtl/vsdf_sqrt.sv
// ----------------------------------------------------------------------------
// vsdf_sqrt
// Pipelined integer floor square root, one result digit per stage, with a
// side tag that travels along with each operand.
// ----------------------------------------------------------------------------
module vsdf_sqrt import vsdf_pkg::*; #(
    parameter int TAG_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [C_SQ_W-1:0]   i_value,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_valid,
    output logic [C_ROOT_W-1:0] o_root,
    output logic [TAG_W-1:0]    o_tag
);

    localparam int K = C_ROOT_W;

    logic              r_v   [K];
    logic [C_SQ_W-1:0] r_n   [K];
    logic [C_SQ_W-1:0] r_res [K];
    logic [TAG_W-1:0]  r_tag [K];

    for (genvar g = 0; g < K; g++) begin : g_stage
        localparam logic [C_SQ_W-1:0] BIT = C_SQ_W'(1) << (2 * (K - 1 - g));

        logic              pv;
        logic [C_SQ_W-1:0] pn, pres, trial, nn, nres;
        logic [TAG_W-1:0]  ptag;

        // Previous stage, or the operand at the head.
        if (g == 0) begin : g_head
            assign pv   = i_valid;
            assign pn   = i_value;
            assign pres = '0;
            assign ptag = i_tag;
        end else begin : g_body
            assign pv   = r_v[g-1];
            assign pn   = r_n[g-1];
            assign pres = r_res[g-1];
            assign ptag = r_tag[g-1];
        end

        // One restoring step.
        always_comb begin
            trial = pres + BIT;
            if (pn >= trial) begin
                nn   = pn - trial;
                nres = (pres >> 1) + BIT;
            end else begin
                nn   = pn;
                nres = pres >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[g]   <= nn;
            r_res[g] <= nres;
            r_tag[g] <= ptag;
        end
    end

    assign o_valid = r_v[K-1];
    assign o_root  = r_res[K-1][C_ROOT_W-1:0];
    assign o_tag   = r_tag[K-1];

endmodule

>>> hw/rtl/voxel_sdf_fill_engine.sv
// ----------------------------------------------------------------------------
// voxel_sdf_fill_engine
// Voxel grid of signed distances, active flags and colors with sphere and
// box fills, clear, cell read and write, and an active cell count.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A sphere fill, box fill, clear or
// count sweeps the cells in use at one cell per cycle through a single-port
// read, single-port write cell store, and then drains the distance and
// square-root pipeline. A cell read or write, or any rejected item, skips
// the sweep. After reset the block first clears the whole store, one cell
// per cycle, and takes no item meanwhile; configuration writes are taken at
// any time. A finished result sits in an output register, so the next item
// is taken while it waits to be collected.
module voxel_sdf_fill_engine import vsdf_pkg::*; #(
    parameter int MAX_CELLS_X = C_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = C_MAX_CELLS_Y,
    parameter int MAX_CELLS_Z = C_MAX_CELLS_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int TOTAL     = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;
    localparam int AW        = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int XW        = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
    localparam int YW        = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
    localparam int ZW        = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1;
    localparam int DRAIN_LEN = C_ROOT_W + 8;
    localparam int TAG_W     = AW + C_DIFF_W;

    // Linear cell address.
    function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y,
                                                logic [ZW-1:0] z);
        return AW'(int'(x) + int'(y) * MAX_CELLS_X + int'(z) * MAX_CELLS_X * MAX_CELLS_Y);
    endfunction

    // Last index in use for a size register value.
    function automatic int last_of(logic [5:0] v, int mx);
        int n;
        n = int'(v);
        if (n == 0) begin
            return 0;
        end
        if (n > mx) begin
            return mx - 1;
        end
        return n - 1;
    endfunction

    t_state             r_state, n_state;
    t_in                r_cmd;
    t_status            r_status;
    logic [XW-1:0]      r_last_x, r_sx, lim_x;
    logic [YW-1:0]      r_last_y, r_sy, lim_y;
    logic [ZW-1:0]      r_last_z, r_sz, lim_z;
    logic [15:0]        r_pitch;
    logic [15:0]        r_cnt;
    logic               r_cnt_v;
    logic [5:0]         r_drain;
    logic               r_out_valid;
    t_out               r_out_data, n_out_data;

    logic               accept, sweep_go, sweep_last, fill_go, clear_go, count_go;
    logic               exec_read, exec_write, emit_load, is_box, idx_ok;
    logic [AW-1:0]      sweep_addr, cmd_addr;

    // Fill pipeline signals.
    t_pt2                       lo [3], hi [3];
    logic [C_IDX_W-1:0]         idx [3];
    logic                       d_valid, q_valid;
    logic [C_SQ_W-1:0]          d_sum;
    logic signed [C_DIFF_W-1:0] d_inside, q_inside;
    logic [AW-1:0]              d_addr, q_addr;
    logic [C_ROOT_W-1:0]        q_root;
    logic [TAG_W-1:0]           q_tag;
    logic signed [23:0]         dq;
    logic                       r_f1_v, r_f2_v;
    logic [AW-1:0]              r_f1_addr, r_f2_addr;
    logic signed [23:0]         r_f1_d, r_f2_d;

    // Store ports.
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_cell         wdata, rdata;

    // ------------------------------------------------------------------------
    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= XW'(last_of(6'd32, MAX_CELLS_X));
            r_last_y <= YW'(last_of(6'd32, MAX_CELLS_Y));
            r_last_z <= ZW'(last_of(6'd32, MAX_CELLS_Z));
            r_pitch  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_CELLS_X:    r_last_x <= XW'(last_of(i_cfg_data[5:0], MAX_CELLS_X));
                REG_CELLS_Y:    r_last_y <= YW'(last_of(i_cfg_data[5:0], MAX_CELLS_Y));
                REG_CELLS_Z:    r_last_z <= ZW'(last_of(i_cfg_data[5:0], MAX_CELLS_Z));
                REG_CELL_PITCH: r_pitch  <= i_cfg_data;
                default:        r_pitch  <= r_pitch;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Decode of the held command.
    assign is_box = (r_cmd.opcode == OP_FILL_BOX);
    assign idx_ok = !r_cmd.point_a_x[23] && !r_cmd.point_a_y[23] && !r_cmd.point_a_z[23]
                 && (r_cmd.point_a_x <= 24'(r_last_x))
                 && (r_cmd.point_a_y <= 24'(r_last_y))
                 && (r_cmd.point_a_z <= 24'(r_last_z));
    assign cmd_addr = cell_addr(XW'(r_cmd.point_a_x), YW'(r_cmd.point_a_y),
                                ZW'(r_cmd.point_a_z));

    // Sweep limits: the whole store during the reset clearing pass.
    assign lim_x      = (r_state == S_INIT) ? XW'(MAX_CELLS_X - 1) : r_last_x;
    assign lim_y      = (r_state == S_INIT) ? YW'(MAX_CELLS_Y - 1) : r_last_y;
    assign lim_z      = (r_state == S_INIT) ? ZW'(MAX_CELLS_Z - 1) : r_last_z;
    assign sweep_last = (r_sx == lim_x) && (r_sy == lim_y) && (r_sz == lim_z);
    assign sweep_addr = cell_addr(r_sx, r_sy, r_sz);

    // ------------------------------------------------------------------------
    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  if (sweep_last) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC: begin
                priority case (r_cmd.opcode)
                    OP_FILL_SPHERE: n_state = (r_cmd.size_or_distance > 0) ? S_SWEEP : S_EMIT;
                    OP_FILL_BOX, OP_CLEAR, OP_COUNT: n_state = S_SWEEP;
                    default: n_state = S_EMIT;
                endcase
            end
            S_SWEEP: if (sweep_last) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == '0) n_state = S_EMIT;
            S_EMIT:  if (emit_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        sweep_go   = (r_state == S_INIT) || (r_state == S_SWEEP);
        fill_go    = (r_state == S_SWEEP)
                  && (r_cmd.opcode == OP_FILL_SPHERE || r_cmd.opcode == OP_FILL_BOX);
        clear_go   = (r_state == S_INIT) || ((r_state == S_SWEEP) && (r_cmd.opcode == OP_CLEAR));
        count_go   = (r_state == S_SWEEP) && (r_cmd.opcode == OP_COUNT);
        exec_read  = (r_state == S_EXEC) && (r_cmd.opcode == OP_READ) && idx_ok;
        exec_write = (r_state == S_EXEC) && (r_cmd.opcode == OP_WRITE) && idx_ok;
        emit_load  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Command beat capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_data;
        end
    end

    // Status of the item, settled in the execute step.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if (r_cmd.opcode == OP_FILL_SPHERE && r_cmd.size_or_distance <= 0) begin
                r_status <= STAT_RADIUS;
            end else if ((r_cmd.opcode == OP_READ || r_cmd.opcode == OP_WRITE) && !idx_ok) begin
                r_status <= STAT_RANGE;
            end else begin
                r_status <= STAT_OK;
            end
        end
    end

    // Sweep counters, x fastest; they wrap back to zero at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
        end else if (sweep_go) begin
            if (r_sx == lim_x) begin
                r_sx <= '0;
                if (r_sy == lim_y) begin
                    r_sy <= '0;
                    r_sz <= (r_sz == lim_z) ? '0 : r_sz + 1'b1;
                end else begin
                    r_sy <= r_sy + 1'b1;
                end
            end else begin
                r_sx <= r_sx + 1'b1;
            end
        end
    end

    // Drain timer for the fill pipeline and the count read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= '0;
        end else if (r_state == S_SWEEP && sweep_last) begin
            r_drain <= 6'(DRAIN_LEN);
        end else if (r_state == S_DRAIN) begin
            r_drain <= r_drain - 1'b1;
        end
    end

    // Active count over read beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_v <= 1'b0;
        end else begin
            r_cnt_v <= count_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_cnt <= '0;
        end else if (r_cnt_v && rdata.active) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shape operands in Q.9; box corners put in order per axis.
    always_comb begin
        t_pt2 a [3];
        t_pt2 b [3];
        a[0] = {r_cmd.point_a_x, 1'b0};
        a[1] = {r_cmd.point_a_y, 1'b0};
        a[2] = {r_cmd.point_a_z, 1'b0};
        b[0] = {r_cmd.point_b_x, 1'b0};
        b[1] = {r_cmd.point_b_y, 1'b0};
        b[2] = {r_cmd.point_b_z, 1'b0};
        for (int k = 0; k < 3; k++) begin
            if (is_box && b[k] < a[k]) begin
                lo[k] = b[k];
                hi[k] = a[k];
            end else begin
                lo[k] = a[k];
                hi[k] = is_box ? b[k] : a[k];
            end
        end
    end

    assign idx[0] = C_IDX_W'(r_sx);
    assign idx[1] = C_IDX_W'(r_sy);
    assign idx[2] = C_IDX_W'(r_sz);

    vsdf_dist #(.AW(AW)) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fill_go),
        .i_box    (is_box),
        .i_idx    (idx),
        .i_pitch  (r_pitch),
        .i_lo     (lo),
        .i_hi     (hi),
        .i_addr   (sweep_addr),
        .o_valid  (d_valid),
        .o_sum    (d_sum),
        .o_inside (d_inside),
        .o_addr   (d_addr)
    );

    vsdf_sqrt #(.TAG_W(TAG_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_value (d_sum),
        .i_tag   ({d_addr, d_inside}),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_tag   (q_tag)
    );

    assign q_addr   = q_tag[TAG_W-1:C_DIFF_W];
    assign q_inside = signed'(q_tag[C_DIFF_W-1:0]);

    // Distance in Q.9, rounded half up to Q15.8 and saturated.
    always_comb begin
        logic signed [C_D9_W-1:0] root, rad, d9;
        logic signed [C_D9_W:0]   t;
        root = signed'(C_D9_W'(q_root));
        rad  = {{(C_D9_W - 25){r_cmd.size_or_distance[23]}}, r_cmd.size_or_distance, 1'b0};
        d9   = is_box ? root + C_D9_W'(q_inside) : root - rad;
        t    = ((C_D9_W + 1)'(d9) + (C_D9_W + 1)'(1)) >>> 1;
        if (t > (C_D9_W + 1)'(C_DIST_INF)) begin
            dq = C_DIST_INF;
        end else if (t < (C_D9_W + 1)'(C_DIST_MIN)) begin
            dq = C_DIST_MIN;
        end else begin
            dq = t[23:0];
        end
    end

    // Read issue and apply stages of the fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= q_valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_addr <= q_addr;
        r_f1_d    <= dq;
        r_f2_addr <= r_f1_addr;
        r_f2_d    <= r_f1_d;
    end

    // ------------------------------------------------------------------------
    // Store port selection.
    always_comb begin
        re    = r_f1_v || count_go || exec_read;
        raddr = r_f1_v ? r_f1_addr : (count_go ? sweep_addr : cmd_addr);
        we    = r_f2_v || clear_go || exec_write;
        waddr = cmd_addr;
        wdata = '{distance: r_cmd.size_or_distance, active: r_cmd.write_active,
                  red: r_cmd.paint_red, green: r_cmd.paint_green, blue: r_cmd.paint_blue};
        if (r_f2_v) begin
            waddr          = r_f2_addr;
            wdata          = rdata;
            wdata.distance = (r_f2_d < rdata.distance) ? r_f2_d : rdata.distance;
            if (r_f2_d <= 0) begin
                wdata.active = 1'b1;
                wdata.red    = r_cmd.paint_red;
                wdata.green  = r_cmd.paint_green;
                wdata.blue   = r_cmd.paint_blue;
            end
        end else if (clear_go) begin
            waddr = sweep_addr;
            wdata = '{distance: C_DIST_INF, active: 1'b0, red: 8'd0, green: 8'd0,
                      blue: 8'd0};
        end
    end

    vsdf_store #(.DEPTH(TOTAL), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // ------------------------------------------------------------------------
    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result fields; those an operation does not produce stay zero.
    always_comb begin
        n_out_data        = '0;
        n_out_data.status = r_status;
        if (r_status == STAT_OK && r_cmd.opcode == OP_READ) begin
            n_out_data.cell_active   = rdata.active;
            n_out_data.cell_red      = rdata.red;
            n_out_data.cell_green    = rdata.green;
            n_out_data.cell_blue     = rdata.blue;
            n_out_data.cell_distance = rdata.distance;
        end
        if (r_cmd.opcode == OP_COUNT) begin
            n_out_data.active_total = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------------
    // Fill writes never meet clear writes on the one write port.
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_f2_v && clear_go))
        else $error("fill apply and clear write in the same cycle");

    // Fill results only land while the fill sweep or its drain is running.
    a_apply_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f2_v |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("fill write outside of a fill");

    // A new result beat only comes from the emit step.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result beat raised outside the emit step");

    // The pipeline is empty when the result is formed.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !(d_valid || q_valid || r_f1_v || r_f2_v))
        else $error("result formed while fill pipeline busy");

endmodule
